// ===== hw/rtl/mvh_pkg.sv =====
// Shared types, constants and command codes of the masked voxel histogram.
// Used by mvh_scan, mvh_bins and the top level; depends on nothing.
package mvh_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COORD_BITS  = 12;
  localparam int COUNT_BITS  = 32;

  localparam int FIELD_BITS  = 16;
  localparam int CMD_BITS    = 2;
  localparam int CW          = COORD_BITS + 1;
  localparam int SQ_BITS     = 2 * CW;
  localparam int BIN_DEPTH   = 1 << SAMPLE_BITS;
  localparam int RESULT_BITS = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  localparam int CROP_MAX_RESET  = 4096;
  localparam int MAX_VALUE_RESET = 65535;

  localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] REG_CROP_MIN_X = 3'd0;
  localparam logic [2:0] REG_CROP_MAX_X = 3'd1;
  localparam logic [2:0] REG_CROP_MIN_Y = 3'd2;
  localparam logic [2:0] REG_CROP_MAX_Y = 3'd3;
  localparam logic [2:0] REG_CYL_EN     = 3'd4;
  localparam logic [2:0] REG_MAX_VALUE  = 3'd5;

  typedef struct packed {
    logic [COORD_BITS-1:0] crop_min_x;
    logic [CW-1:0]         crop_max_x;
    logic [COORD_BITS-1:0] crop_min_y;
    logic [CW-1:0]         crop_max_y;
    logic                  cylinder_enable;
    logic [FIELD_BITS-1:0] max_value;
  } mvh_cfg_t;

  typedef struct packed {
    logic                  vld;
    logic [CMD_BITS-1:0]   cmd;
    logic [FIELD_BITS-1:0] sample;
    logic [FIELD_BITS-1:0] bin_index;
    logic                  in_mask;
  } mvh_op_t;

  typedef struct packed {
    logic [RESULT_BITS-1:0] bin_count;
    logic                   out_of_range_seen;
  } mvh_res_t;

endpackage

// ===== hw/rtl/mvh_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Read-first on an address collision; no dependencies.
module mvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mvh_scan.sv =====
// Scan position tracking and the three-stage cylinder mask test.
// Depends on mvh_pkg; feeds mvh_bins with one operation per advancing cycle.
module mvh_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  mvh_pkg::mvh_cfg_t              cfg,
  input  logic                           acc,
  input  logic [mvh_pkg::CMD_BITS-1:0]   cmd,
  input  logic [mvh_pkg::FIELD_BITS-1:0] sample,
  input  logic [mvh_pkg::FIELD_BITS-1:0] bin_index,
  output mvh_pkg::mvh_op_t               op
);
  import mvh_pkg::*;

  logic [CW-1:0] scan_x_r, scan_y_r;
  logic [CW-1:0] scan_x_nxt, scan_y_nxt;
  logic [CW:0]   nx, ny;
  logic [CW-1:0] min_x, min_y;
  logic [CW:0]   cx_sum, cy_sum;
  logic [CW-1:0] cx, cy;
  logic [CW:0]   dx, dy, dw;
  logic [CW-1:0] adx, ady, adw;

  logic                  s1_vld_r;
  logic [CMD_BITS-1:0]   s1_cmd_r;
  logic [FIELD_BITS-1:0] s1_sample_r, s1_index_r;
  logic [CW-1:0]         s1_adx_r, s1_ady_r, s1_half_r;

  logic                  s2_vld_r;
  logic [CMD_BITS-1:0]   s2_cmd_r;
  logic [FIELD_BITS-1:0] s2_sample_r, s2_index_r;
  logic [SQ_BITS-1:0]    s2_dx2_r, s2_dy2_r, s2_h2_r;

  logic [SQ_BITS:0]      dist2;
  logic                  op_vld_r;
  logic [CMD_BITS-1:0]   op_cmd_r;
  logic [FIELD_BITS-1:0] op_sample_r, op_index_r;
  logic                  op_mask_r;

  assign min_x = CW'(cfg.crop_min_x);
  assign min_y = CW'(cfg.crop_min_y);

  always_comb begin
    nx = {1'b0, scan_x_r} + (CW+1)'(1);
    ny = {1'b0, scan_y_r} + (CW+1)'(1);
    scan_x_nxt = scan_x_r;
    scan_y_nxt = scan_y_r;
    if (cmd == CMD_CLEAR) begin
      scan_x_nxt = min_x;
      scan_y_nxt = min_y;
    end else if (cmd == CMD_SAMPLE) begin
      if (nx >= {1'b0, cfg.crop_max_x}) begin
        scan_x_nxt = min_x;
        scan_y_nxt = (ny >= {1'b0, cfg.crop_max_y}) ? min_y : ny[CW-1:0];
      end else begin
        scan_x_nxt = nx[CW-1:0];
      end
    end
  end

  always_comb begin
    cx_sum = {1'b0, min_x} + {1'b0, cfg.crop_max_x};
    cy_sum = {1'b0, min_y} + {1'b0, cfg.crop_max_y};
    cx = cx_sum[CW:1];
    cy = cy_sum[CW:1];
    dx = {1'b0, scan_x_r} - {1'b0, cx};
    dy = {1'b0, scan_y_r} - {1'b0, cy};
    dw = {1'b0, cfg.crop_max_x} - {1'b0, min_x};
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    adw = dw[CW] ? CW'(-dw) : dw[CW-1:0];
  end

  assign dist2 = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_x_r <= '0;
      scan_y_r <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      op_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        scan_x_r <= scan_x_nxt;
        scan_y_r <= scan_y_nxt;
      end
      if (adv) begin
        s1_vld_r <= acc;
        s2_vld_r <= s1_vld_r;
        op_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r    <= cmd;
      s1_sample_r <= sample;
      s1_index_r  <= bin_index;
      s1_adx_r    <= adx;
      s1_ady_r    <= ady;
      s1_half_r   <= adw >> 1;

      s2_cmd_r    <= s1_cmd_r;
      s2_sample_r <= s1_sample_r;
      s2_index_r  <= s1_index_r;
      s2_dx2_r    <= s1_adx_r * s1_adx_r;
      s2_dy2_r    <= s1_ady_r * s1_ady_r;
      s2_h2_r     <= s1_half_r * s1_half_r;

      op_cmd_r    <= s2_cmd_r;
      op_sample_r <= s2_sample_r;
      op_index_r  <= s2_index_r;
      op_mask_r   <= !cfg.cylinder_enable || (dist2 <= {1'b0, s2_h2_r});
    end
  end

  assign op = '{vld: op_vld_r, cmd: op_cmd_r, sample: op_sample_r, bin_index: op_index_r,
                in_mask: op_mask_r};

endmodule

// ===== hw/rtl/mvh_bins.sv =====
// Bin store read-modify-write with write forwarding, sticky range flag and clear sweep.
// Depends on mvh_pkg and mvh_ram; takes operations from mvh_scan.
module mvh_bins (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [mvh_pkg::FIELD_BITS-1:0] max_value,
  input  mvh_pkg::mvh_op_t               op,
  output logic                           res_vld,
  output mvh_pkg::mvh_res_t              res,
  output logic                           clr_done
);
  import mvh_pkg::*;

  logic [SAMPLE_BITS-1:0] raddr;
  logic [COUNT_BITS-1:0]  rdata;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata;

  logic                   flag_r;
  logic                   s4_inc_r, s4_read_r, s4_flag_r;
  logic [SAMPLE_BITS-1:0] s4_addr_r;

  logic                   wr_vld_r;
  logic [SAMPLE_BITS-1:0] wr_addr_r;
  logic [COUNT_BITS-1:0]  wr_data_r;

  logic                   sweep_r;
  logic [SAMPLE_BITS-1:0] sweep_addr_r;

  logic [COUNT_BITS-1:0]  cur, inc_data;
  logic [63:0]            cur64;
  logic                   s4_we;
  logic                   is_sample, is_read, is_clear;

  assign is_sample = op.vld && (op.cmd == CMD_SAMPLE);
  assign is_read   = op.vld && (op.cmd == CMD_READ);
  assign is_clear  = op.vld && (op.cmd == CMD_CLEAR);

  assign raddr = is_read ? op.bin_index[SAMPLE_BITS-1:0] : op.sample[SAMPLE_BITS-1:0];

  assign cur      = (wr_vld_r && (wr_addr_r == s4_addr_r)) ? wr_data_r : rdata;
  assign inc_data = (&cur) ? cur : cur + COUNT_BITS'(1);
  assign s4_we    = adv && s4_inc_r;

  assign ram_we    = sweep_r || s4_we;
  assign ram_waddr = sweep_r ? sweep_addr_r : s4_addr_r;
  assign ram_wdata = sweep_r ? '0 : inc_data;

  mvh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BIN_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r       <= 1'b0;
      s4_inc_r     <= 1'b0;
      s4_read_r    <= 1'b0;
      wr_vld_r     <= 1'b0;
      sweep_r      <= 1'b1;
      sweep_addr_r <= '0;
    end else begin
      if (adv) begin
        s4_inc_r  <= is_sample && op.in_mask && (op.sample <= max_value);
        s4_read_r <= is_read;
        if (is_clear) begin
          flag_r <= 1'b0;
        end else if (is_sample && op.in_mask && (op.sample > max_value)) begin
          flag_r <= 1'b1;
        end
      end
      if (ram_we) begin
        wr_vld_r <= 1'b1;
      end else if (adv) begin
        wr_vld_r <= 1'b0;
      end
      if (sweep_r) begin
        sweep_addr_r <= sweep_addr_r + SAMPLE_BITS'(1);
        if (&sweep_addr_r) begin
          sweep_r <= 1'b0;
        end
      end else if (adv && is_clear) begin
        sweep_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_addr_r <= raddr;
      s4_flag_r <= flag_r;
    end
    if (ram_we) begin
      wr_addr_r <= ram_waddr;
      wr_data_r <= ram_wdata;
    end
  end

  assign cur64                 = 64'(cur);
  assign res_vld               = s4_read_r;
  assign res.bin_count         = (cur64 > 64'hFFFF_FFFF) ? '1 : cur64[RESULT_BITS-1:0];
  assign res.out_of_range_seen = s4_flag_r;
  assign clr_done              = sweep_r && (&sweep_addr_r);

endmodule

// ===== hw/rtl/masked_voxel_histogram_top.sv =====
// Top level of the masked voxel histogram: configuration registers, stream ports, output register.
// Depends on mvh_pkg, mvh_scan and mvh_bins.
//
// Usage: commands enter on the in_ stream, one transaction each. A sample command counts the
// voxel value at the current scan position into its bin if it lies in the mask and is at most
// max_value, and advances the position; a read command returns one bin count and the sticky
// out-of-range flag on the out_ stream; a clear command zeroes all bins and the flag and restarts
// the position at the crop start. Registers are written over the APB-style cfg_ port; the user
// must write them only while the block is idle, which the block does not enforce. A read result
// passes stages s1, s2, op, s4 and the output register. One command per cycle while in_tready is
// high; each sample does one read-modify-write of the bin RAM, and forwarding of the last write
// keeps back-to-back hits on one bin at full rate. A clear waits for the pipeline to drain and
// then sweeps the bin RAM one entry per cycle, with in_tready low. The same sweep runs after reset,
// so the block takes its first command after that sweep; configuration writes are taken
// throughout. While a result waits in the output register, commands keep flowing until a second
// read result arrives behind it; then the whole pipeline holds until out_tready takes the first.
module masked_voxel_histogram_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // sample[15:0], bin_index[31:16]
  input  logic [1:0]                   in_tuser,   // command[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // bin_count[31:0]
  output logic [0:0]                   out_tuser,  // out_of_range_seen[0]
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [mvh_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [mvh_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [mvh_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import mvh_pkg::*;

  mvh_cfg_t cfg_r;
  mvh_op_t  op;
  mvh_res_t res;
  mvh_res_t out_r;
  logic     out_valid_r;
  logic     clr_hold_r;
  logic     res_vld, clr_done;
  logic     adv, acc, cfg_wr;
  logic [2:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crop_min_x      <= '0;
      cfg_r.crop_max_x      <= CW'(CROP_MAX_RESET);
      cfg_r.crop_min_y      <= '0;
      cfg_r.crop_max_y      <= CW'(CROP_MAX_RESET);
      cfg_r.cylinder_enable <= 1'b0;
      cfg_r.max_value       <= FIELD_BITS'(MAX_VALUE_RESET);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CROP_MIN_X: cfg_r.crop_min_x      <= cfg_pwdata[COORD_BITS-1:0];
        REG_CROP_MAX_X: cfg_r.crop_max_x      <= cfg_pwdata[CW-1:0];
        REG_CROP_MIN_Y: cfg_r.crop_min_y      <= cfg_pwdata[COORD_BITS-1:0];
        REG_CROP_MAX_Y: cfg_r.crop_max_y      <= cfg_pwdata[CW-1:0];
        REG_CYL_EN:     cfg_r.cylinder_enable <= cfg_pwdata[0];
        REG_MAX_VALUE:  cfg_r.max_value       <= cfg_pwdata[FIELD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CROP_MIN_X: cfg_prdata = CFG_DW'(cfg_r.crop_min_x);
      REG_CROP_MAX_X: cfg_prdata = CFG_DW'(cfg_r.crop_max_x);
      REG_CROP_MIN_Y: cfg_prdata = CFG_DW'(cfg_r.crop_min_y);
      REG_CROP_MAX_Y: cfg_prdata = CFG_DW'(cfg_r.crop_max_y);
      REG_CYL_EN:     cfg_prdata = CFG_DW'(cfg_r.cylinder_enable);
      REG_MAX_VALUE:  cfg_prdata = CFG_DW'(cfg_r.max_value);
      default:        cfg_prdata = '0;
    endcase
  end

  assign adv       = !(out_valid_r && !out_tready && res_vld);
  assign in_tready = adv && !clr_hold_r;
  assign acc       = in_tvalid && in_tready;

  mvh_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .cfg      (cfg_r),
    .acc      (acc),
    .cmd      (in_tuser[CMD_BITS-1:0]),
    .sample   (in_tdata[FIELD_BITS-1:0]),
    .bin_index(in_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .op       (op)
  );

  mvh_bins u_bins (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .max_value(cfg_r.max_value),
    .op       (op),
    .res_vld  (res_vld),
    .res      (res),
    .clr_done (clr_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_hold_r  <= 1'b1;
    end else begin
      if (adv && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clr_done) begin
        clr_hold_r <= 1'b0;
      end else if (acc && (in_tuser[CMD_BITS-1:0] == CMD_CLEAR)) begin
        clr_hold_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.bin_count;
  assign out_tuser[0] = out_r.out_of_range_seen;

endmodule
